/* design/pip_pkg.sv */
// Package for the point-in-polygon crossing test: shared types and constants.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package pip_pkg;

  // Fixed width of the reported crossing total.
  localparam int RESULT_BITS = 16;

  // Per-edge control that travels from the edge stage to the count stage.
  typedef struct packed {
    logic valid;     // product register holds an edge
    logic crossing;  // endpoint y values on opposite sides of the point
    logic end_neg;   // end vertex below the point, edge runs downward
    logic last;      // final edge of the polygon
  } pip_edge_ctl_t;

endpackage

`default_nettype wire

/* design/pip_if.sv */
// Valid/ready stream interfaces for edge transactions and result transactions.
// Depends on pip_pkg for the result width.
`default_nettype none

interface pip_edge_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic                         last_edge;

  modport source (
    output valid, point_x, point_y, start_x, start_y, end_x, end_y, last_edge,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, start_x, start_y, end_x, end_y, last_edge,
    output ready
  );
endinterface

interface pip_result_if;
  logic                             valid;
  logic                             ready;
  logic                             in_polygon;
  logic [pip_pkg::RESULT_BITS-1:0]  crossing_total;

  modport source (output valid, in_polygon, crossing_total, input ready);
  modport sink (input valid, in_polygon, crossing_total, output ready);
endinterface

`default_nettype wire

/* design/pip_edge_stage.sv */
// Edge stage: input register, shift by the query point, two cross products.
// Depends on pip_pkg and pip_edge_if.
`default_nettype none

module pip_edge_stage #(
  parameter int COORD_BITS = 16,
  parameter int PROD_BITS  = 2 * COORD_BITS + 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  pip_edge_if.sink                    edge_i,
  input  wire logic                   take_i,
  output pip_pkg::pip_edge_ctl_t      ctl_o,
  output logic signed [PROD_BITS-1:0] prod_se_o,
  output logic signed [PROD_BITS-1:0] prod_es_o
);

  localparam int DIFF_BITS = COORD_BITS + 1;

  // Input register
  logic                         a_valid_q;
  logic signed [COORD_BITS-1:0] a_point_x_q, a_point_y_q;
  logic signed [COORD_BITS-1:0] a_start_x_q, a_start_y_q;
  logic signed [COORD_BITS-1:0] a_end_x_q, a_end_y_q;
  logic                         a_last_q;

  // Product register
  logic                         b_valid_q;
  logic                         b_crossing_q, b_end_neg_q, b_last_q;
  logic signed [PROD_BITS-1:0]  b_prod_se_q, b_prod_es_q;

  logic                         a_load, b_load;
  logic signed [DIFF_BITS-1:0]  sx, sy, ex, ey;
  logic signed [PROD_BITS-1:0]  prod_se, prod_es;

  // Each register loads when empty or when its content moves on.
  assign b_load       = !b_valid_q || take_i;
  assign a_load       = !a_valid_q || b_load;
  assign edge_i.ready = a_load;

  // Shift the edge so the query point sits at the origin.
  assign sx = DIFF_BITS'(a_start_x_q) - DIFF_BITS'(a_point_x_q);
  assign sy = DIFF_BITS'(a_start_y_q) - DIFF_BITS'(a_point_y_q);
  assign ex = DIFF_BITS'(a_end_x_q) - DIFF_BITS'(a_point_x_q);
  assign ey = DIFF_BITS'(a_end_y_q) - DIFF_BITS'(a_point_y_q);

  assign prod_se = PROD_BITS'(sx) * PROD_BITS'(ey);
  assign prod_es = PROD_BITS'(sy) * PROD_BITS'(ex);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_q <= edge_i.valid;
      end
      if (b_load) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_i.valid && a_load) begin
      a_point_x_q <= edge_i.point_x;
      a_point_y_q <= edge_i.point_y;
      a_start_x_q <= edge_i.start_x;
      a_start_y_q <= edge_i.start_y;
      a_end_x_q   <= edge_i.end_x;
      a_end_y_q   <= edge_i.end_y;
      a_last_q    <= edge_i.last_edge;
    end
    if (a_valid_q && b_load) begin
      b_crossing_q <= sy[DIFF_BITS-1] ^ ey[DIFF_BITS-1];
      b_end_neg_q  <= ey[DIFF_BITS-1];
      b_last_q     <= a_last_q;
      b_prod_se_q  <= prod_se;
      b_prod_es_q  <= prod_es;
    end
  end

  assign ctl_o = '{valid:    b_valid_q,
                   crossing: b_crossing_q,
                   end_neg:  b_end_neg_q,
                   last:     b_last_q};
  assign prod_se_o = b_prod_se_q;
  assign prod_es_o = b_prod_es_q;

endmodule

`default_nettype wire

/* design/pip_count_stage.sv */
// Count stage: crossing decision, running count, mode register, result register.
// Depends on pip_pkg and pip_result_if.
`default_nettype none

module pip_count_stage #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16,
  parameter int PROD_BITS  = 2 * COORD_BITS + 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pip_pkg::pip_edge_ctl_t      ctl_i,
  input  wire logic signed [PROD_BITS-1:0] prod_se_i,
  input  wire logic signed [PROD_BITS-1:0] prod_es_i,
  output logic                             take_o,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_data_i,
  pip_result_if.source                     result_o
);

  logic                            strict_q;
  logic [COUNT_BITS-1:0]           count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic                            in_polygon_q;
  logic [pip_pkg::RESULT_BITS-1:0] total_q, total_w;

  logic gt, eq, hit, take;
  logic [COUNT_BITS-1:0] count_inc;

  // Numerator sign without negation: a downward edge flips the test.
  assign gt  = prod_se_i > prod_es_i;
  assign eq  = prod_se_i == prod_es_i;
  assign hit = ctl_i.crossing &&
               (ctl_i.end_neg ? (strict_q ? (!gt && !eq) : !gt)
                              : (strict_q ? gt : (gt || eq)));

  // A last edge needs a free result slot; other edges always drain.
  assign take   = ctl_i.valid && (!ctl_i.last || !out_valid_q || result_o.ready);
  assign take_o = take;

  assign count_inc = count_q + COUNT_BITS'(hit);

  if (COUNT_BITS >= pip_pkg::RESULT_BITS) begin : g_total_trunc
    assign total_w = count_inc[pip_pkg::RESULT_BITS-1:0];
  end else begin : g_total_ext
    assign total_w = {{(pip_pkg::RESULT_BITS-COUNT_BITS){1'b0}}, count_inc};
  end

  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q && !result_o.ready;
    if (take) begin
      if (ctl_i.last) begin
        count_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        strict_q <= cfg_data_i;
      end
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctl_i.last) begin
      in_polygon_q <= count_inc[0];
      total_q      <= total_w;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.in_polygon     = in_polygon_q;
  assign result_o.crossing_total = total_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctl_i.last |=> out_valid_q)
    else $error("last edge taken without a result");

  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && ctl_i.last |=> count_q == '0)
    else $error("count not cleared after last edge");

  a_miss_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take && (hit || ctl_i.last)) |=> $stable(count_q))
    else $error("count changed without a counted crossing");

  a_parity_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_polygon_q == total_q[0])
    else $error("inside flag disagrees with crossing total");

endmodule

`default_nettype wire

/* design/point_in_polygon_crossing_test_core.sv */
// Top level of the point-in-polygon crossing test.
// Depends on pip_pkg, pip_if, pip_edge_stage and pip_count_stage.
//
// Usage:
// - edge_i carries one polygon edge per transaction, together with the query
//   point; last_edge marks the final edge of the polygon.
// - result_o carries one transaction per polygon: in_polygon (odd crossing
//   count) and crossing_total, counted modulo 2^COUNT_BITS and cut to RESULT_BITS.
// - cfg_we_i/cfg_data_i write strict_crossing: 0 counts a crossing at or to
//   the right of the point, 1 only strictly to the right. Write it between
//   polygons while the block is idle.
// - A result reaches result_o once the edge transaction that carries last_edge
//   has passed the input register, the product register and the result register.
// - Throughput: one edge per cycle unless a last edge waits for the result
//   slot; the input register, the product register and the count/result
//   register each advance only when their content can move on.
// - Reset clears the running count, the mode register and all valid flags.
// - When the receiver stalls, the result register holds; edges that are not
//   last keep draining into the count, and a last edge waits in the product
//   register until the result slot frees, while backpressure reaches edge_i.
`default_nettype none

module point_in_polygon_crossing_test_core #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  pip_edge_if.sink     edge_i,
  pip_result_if.source result_o,
  input  wire logic    cfg_we_i,
  input  wire logic    cfg_data_i
);

  // Products of two shifted coordinates, each one bit wider than a field.
  localparam int PROD_BITS = 2 * COORD_BITS + 2;

  pip_pkg::pip_edge_ctl_t      edge_ctl;
  logic signed [PROD_BITS-1:0] prod_se;
  logic signed [PROD_BITS-1:0] prod_es;
  logic                        take;

  // Shift and multiply: input register to product register.
  pip_edge_stage #(
    .COORD_BITS (COORD_BITS),
    .PROD_BITS  (PROD_BITS)
  ) u_edge_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .edge_i    (edge_i),
    .take_i    (take),
    .ctl_o     (edge_ctl),
    .prod_se_o (prod_se),
    .prod_es_o (prod_es)
  );

  // Compare, count and report: product register to result register.
  pip_count_stage #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .PROD_BITS  (PROD_BITS)
  ) u_count_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (edge_ctl),
    .prod_se_i  (prod_se),
    .prod_es_i  (prod_es),
    .take_o     (take),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

/* tb/tb_point_in_polygon_crossing_test_core.sv */
// Self-checking testbench for point_in_polygon_crossing_test_core.
// Depends on pip_pkg, the pip_edge_if/pip_result_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb_point_in_polygon_crossing_test_core;

  localparam int COORD_BITS     = 16;
  localparam int COUNT_BITS     = 16;
  localparam int RESET_CYCLES   = 8;
  localparam int DRAIN_CYCLES   = 6;     // pipeline is three registers deep; leave margin
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int MAX_REPORTS    = 10;
  localparam int MAX_VERTICES   = 12;
  localparam int PHASE_EDGES    = 250;

  localparam bit MODE_INCLUSIVE = 1'b0;
  localparam bit MODE_STRICT    = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One edge transaction: the query point and one polygon edge.
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    logic   last_edge;
  } polygon_edge_t;

  // One result transaction per closed polygon.
  typedef struct packed {
    logic                            in_polygon;
    logic [pip_pkg::RESULT_BITS-1:0] crossing_total;
  } polygon_result_t;

  // Crossing-number predictor plus the queue of results still owed by the core.
  class crossing_scoreboard;
    bit                    strict_mode;
    bit [COUNT_BITS-1:0]   running_count;
    polygon_result_t       owed_results[$];
    int                    faults;
    int                    edges_seen;
    int                    crossings_seen;
    int                    results_seen;

    function new();
      strict_mode    = MODE_INCLUSIVE;
      running_count  = '0;
      faults         = 0;
      edges_seen     = 0;
      crossings_seen = 0;
      results_seen   = 0;
    endfunction

    // Shift the edge by the point and test the crossing without division.
    function bit edge_crosses(polygon_edge_t e);
      longint sx, sy, ex, ey, num;
      bit     s_neg, e_neg;
      sx    = longint'(e.start_x) - longint'(e.point_x);
      sy    = longint'(e.start_y) - longint'(e.point_y);
      ex    = longint'(e.end_x) - longint'(e.point_x);
      ey    = longint'(e.end_y) - longint'(e.point_y);
      s_neg = sy < 0;
      e_neg = ey < 0;
      if (s_neg == e_neg) return 1'b0;
      num = sx * ey - sy * ex;
      if (e_neg) num = -num;
      return strict_mode ? (num > 0) : (num >= 0);
    endfunction

    function void note_edge(polygon_edge_t e);
      polygon_result_t res;
      edges_seen++;
      if (edge_crosses(e)) begin
        running_count++;
        crossings_seen++;
      end
      if (e.last_edge) begin
        res.in_polygon     = running_count[0];
        res.crossing_total = running_count;
        owed_results.push_back(res);
        running_count = '0;
      end
    endfunction

    function void check_result(polygon_result_t got);
      polygon_result_t want;
      results_seen++;
      if (owed_results.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("[%0t] unexpected result: inside=%0b total=%0d",
                   $realtime, got.in_polygon, got.crossing_total);
        return;
      end
      want = owed_results.pop_front();
      if (got.in_polygon !== want.in_polygon ||
          got.crossing_total !== want.crossing_total) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display({"[%0t] result mismatch: expected inside=%0b total=%0d, ",
                    "got inside=%0b total=%0d"},
                   $realtime, want.in_polygon, want.crossing_total,
                   got.in_polygon, got.crossing_total);
      end
    endfunction

    function int pending();
      return owed_results.size();
    endfunction
  endclass

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  // Locally held drive values, mapped onto the interfaces below
  polygon_edge_t edge_data    = '0;
  logic          edge_valid   = 1'b0;
  logic          result_ready = 1'b0;
  logic          cfg_we       = 1'b0;
  logic          cfg_data     = 1'b0;
  bit            idle_on      = 1'b0;

  pip_edge_if #(.COORD_BITS(COORD_BITS)) edge_if ();
  pip_result_if result_if ();

  assign edge_if.valid     = edge_valid;
  assign edge_if.point_x   = edge_data.point_x;
  assign edge_if.point_y   = edge_data.point_y;
  assign edge_if.start_x   = edge_data.start_x;
  assign edge_if.start_y   = edge_data.start_y;
  assign edge_if.end_x     = edge_data.end_x;
  assign edge_if.end_y     = edge_data.end_y;
  assign edge_if.last_edge = edge_data.last_edge;
  assign result_if.ready   = result_ready;

  point_in_polygon_crossing_test_core #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .edge_i    (edge_if),
    .result_o  (result_if),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data)
  );

  crossing_scoreboard sb;

  // Monitor: note every accepted edge, check every accepted result, and
  // bail out when the interface has been silent for too long.
  int silent_cycles = 0;
  always @(posedge clk_i) begin
    polygon_edge_t   seen_edge;
    polygon_result_t seen_result;
    if (rst_ni) begin
      if (edge_if.valid && edge_if.ready) begin
        seen_edge.point_x   = edge_if.point_x;
        seen_edge.point_y   = edge_if.point_y;
        seen_edge.start_x   = edge_if.start_x;
        seen_edge.start_y   = edge_if.start_y;
        seen_edge.end_x     = edge_if.end_x;
        seen_edge.end_y     = edge_if.end_y;
        seen_edge.last_edge = edge_if.last_edge;
        sb.note_edge(seen_edge);
      end
      if (result_if.valid && result_if.ready) begin
        seen_result.in_polygon     = result_if.in_polygon;
        seen_result.crossing_total = result_if.crossing_total;
        sb.check_result(seen_result);
      end
      if ((edge_if.valid && edge_if.ready) || (result_if.valid && result_if.ready))
        silent_cycles = 0;
      else
        silent_cycles++;
      if (silent_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d silent cycles", silent_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: drop ready in random stall bursts while idling is enabled,
  // otherwise hold ready high.
  int stall_hold = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      result_ready <= rst_ni;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      result_ready <= 1'b0;
      stall_hold = $urandom_range(1, 8) - 1;
    end else begin
      result_ready <= 1'b1;
      stall_hold = $urandom_range(0, 15);
    end
  end

  // Present one edge transaction and hold it until the core accepts it.
  // An optional idle burst goes in front of it.
  task automatic send_edge(polygon_edge_t e);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      edge_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    edge_valid <= 1'b1;
    edge_data  <= e;
    @(posedge clk_i);
    while (!edge_if.ready) @(posedge clk_i);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline empty.
  task automatic drain();
    edge_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the crossing mode; only ever called with the core idle.
  task automatic write_mode(bit strict);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= strict;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.strict_mode = strict;
  endtask

  function automatic polygon_edge_t mk_edge(int px, int py, int sx, int sy,
                                            int ex, int ey, bit last);
    polygon_edge_t e;
    e.point_x   = px[COORD_BITS-1:0];
    e.point_y   = py[COORD_BITS-1:0];
    e.start_x   = sx[COORD_BITS-1:0];
    e.start_y   = sy[COORD_BITS-1:0];
    e.end_x     = ex[COORD_BITS-1:0];
    e.end_y     = ey[COORD_BITS-1:0];
    e.last_edge = last;
    return e;
  endfunction

  // Pick a coordinate: extremes, fully random, or near the given center so
  // that vertices often sit on the point's horizontal line.
  function automatic coord_t pick_coord(coord_t center);
    case ($urandom_range(0, 9))
      0:       pick_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       pick_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
      2, 3:    pick_coord = coord_t'($urandom);
      4, 5, 6: pick_coord = center + coord_t'(int'($urandom_range(0, 12)) - 6);
      default: pick_coord = center + coord_t'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Directed edges: single-edge polygons, on-line vertices, a crossing right
  // at the point, a square, and coordinate extremes.
  task automatic run_directed();
    send_edge(mk_edge(0, 0, 5, -1, 5, 1, 1'b1));         // lone edge crossing right
    send_edge(mk_edge(0, 0, 3, 2, 4, 5, 1'b1));          // lone edge above the point
    send_edge(mk_edge(0, 0, 0, -1, 0, 1, 1'b1));         // crossing exactly at the point
    send_edge(mk_edge(0, 0, 2, 0, 2, -3, 1'b1));         // start vertex on the line
    send_edge(mk_edge(0, 0, 1, 0, 5, 0, 1'b1));          // horizontal edge on the line
    send_edge(mk_edge(0, 0, 5, 1, 5, -1, 1'b1));         // downward crossing
    send_edge(mk_edge(0, 0, -5, -1, -5, 1, 1'b1));       // crossing left of the point
    send_edge(mk_edge(10, 10, 5, 5, 15, 5, 1'b0));       // square around the point
    send_edge(mk_edge(10, 10, 15, 5, 15, 15, 1'b0));
    send_edge(mk_edge(10, 10, 15, 15, 5, 15, 1'b0));
    send_edge(mk_edge(10, 10, 5, 15, 5, 5, 1'b1));
    send_edge(mk_edge(0, 0, 32767, -32768, 32767, 32767, 1'b1));
    send_edge(mk_edge(32767, 32767, -32768, -32768, -32768, 32767, 1'b1));
    send_edge(mk_edge(-32768, 0, 32767, 32767, -32768, -32768, 1'b1));
    send_edge(mk_edge(-32768, -32768, 32767, -32768, 32767, 32767, 1'b1));
  endtask

  // Random stimulus: mostly closed polygons around one point, some stray
  // edges with unrelated points and random last flags.
  task automatic run_random(int edge_budget);
    int     sent;
    int     n;
    coord_t px, py;
    coord_t vx[MAX_VERTICES];
    coord_t vy[MAX_VERTICES];
    polygon_edge_t e;
    sent = 0;
    while (sent < edge_budget) begin
      if ($urandom_range(0, 4) != 0) begin
        n  = $urandom_range(1, MAX_VERTICES);
        px = pick_coord(coord_t'($urandom));
        py = pick_coord(coord_t'($urandom));
        for (int i = 0; i < n; i++) begin
          vx[i] = pick_coord(px);
          vy[i] = pick_coord(py);
        end
        for (int i = 0; i < n; i++) begin
          e.point_x   = px;
          e.point_y   = py;
          e.start_x   = vx[i];
          e.start_y   = vy[i];
          e.end_x     = vx[(i + 1) % n];
          e.end_y     = vy[(i + 1) % n];
          e.last_edge = (i == n - 1);
          send_edge(e);
        end
        sent += n;
      end else begin
        e           = polygon_edge_t'({$urandom, $urandom, $urandom, $urandom});
        e.last_edge = ($urandom_range(0, 3) == 0);
        send_edge(e);
        sent++;
      end
    end
  endtask

  // Main sequence
  initial begin
    int total_faults;
    sb = new();

    // Hold reset, then release it on a clock edge.
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass under the reset mode, then under each written mode.
    idle_on = 1'b1;
    run_directed();
    write_mode(MODE_STRICT);
    run_directed();
    write_mode(MODE_INCLUSIVE);
    run_directed();

    // Random phases, alternating modes; the final phase runs without idling.
    write_mode(MODE_STRICT);
    run_random(PHASE_EDGES);
    write_mode(MODE_INCLUSIVE);
    run_random(PHASE_EDGES);
    write_mode(MODE_STRICT);
    run_random(PHASE_EDGES);
    write_mode(MODE_INCLUSIVE);
    run_random(PHASE_EDGES);
    write_mode(bit'($urandom_range(0, 1)));
    run_random(PHASE_EDGES);
    idle_on = 1'b0;
    write_mode(bit'($urandom_range(0, 1)));
    run_random(PHASE_EDGES);

    // Let everything drain, then tally up.
    drain();
    total_faults = sb.faults + sb.pending();
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("Run covered %0d edges in %0d returned polygons, %0d counted crossings,",
             sb.edges_seen, sb.results_seen, sb.crossings_seen);
    $display("both crossing modes and stalls on both sides; %0d faults",
             total_faults);
    if (total_faults == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
